// ----- hdl/nsr_pkg.sv -----
// Package for the Newton square root block: field widths, parameter defaults
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none
package nsr_pkg;

	localparam int NUM_W              = 48;
	localparam int ROOT_W             = 32;
	localparam int EPS_W              = 32;
	localparam int GUESS_W            = 64;
	localparam int MAX_ITERATIONS_DEF = 64;
	localparam int FRAC_BITS_DEF      = 16;
	localparam logic [EPS_W-1:0] EPS_RESET = 32'd1;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic update;
		logic advance;
		logic write_result;
		logic not_conv;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic special;
		logic converged;
	} status_t;

endpackage
`default_nettype wire

// ----- hdl/newton_square_root.sv -----
// Top level of the Newton square root block: joins controller and datapath.
// Depends on nsr_pkg, nsr_ctrl and nsr_dp.
//
// Input channel in_valid/in_ready carries num, a signed fixed-point operand
// with FRAC_BITS fraction bits. Output channel out_valid/out_ready carries
// root (unsigned, FRAC_BITS fraction bits), invalid and not_converged.
// cfg_we/cfg_wdata write the epsilon tolerance (reset value one LSB).
// One transaction is worked at a time. Negative, zero and exactly-one
// operands are finished in CLASSIFY without any Newton update. Otherwise
// each Newton update runs DIV_INIT, DIVIDE (the one-bit-per-cycle restoring
// divider), UPDATE and CHECK, and at most MAX_ITERATIONS updates are run.
// A finished result sits in the output register; the next transaction is
// accepted while it waits. If the receiver still stalls when the following
// result is ready, the block holds that result and takes no new input.
// Reset clears the controller and valid flags and sets epsilon to one LSB.
`default_nettype none
module newton_square_root #(
	parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF,
	parameter int FRAC_BITS      = nsr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [nsr_pkg::NUM_W-1:0]   num,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [nsr_pkg::ROOT_W-1:0]  root,
	output logic                             invalid,
	output logic                             not_converged,
	input  wire logic                        cfg_we,
	input  wire logic [nsr_pkg::EPS_W-1:0]   cfg_wdata
);

	nsr_pkg::cmd_t    cmd;
	nsr_pkg::status_t status;

	nsr_ctrl #(
		.MAX_ITERATIONS(MAX_ITERATIONS),
		.DIV_STEPS     (nsr_pkg::NUM_W + FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	nsr_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.num          (num),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.status       (status),
		.root         (root),
		.invalid      (invalid),
		.not_converged(not_converged)
	);

endmodule
`default_nettype wire

// ----- hdl/nsr_dp.sv -----
// Datapath of the Newton square root block: operand and guess registers,
// restoring divider, update and tolerance compare, result register.
// Depends on nsr_pkg.
`default_nettype none
module nsr_dp #(
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [nsr_pkg::NUM_W-1:0]    num,
	input  wire logic                         cfg_we,
	input  wire logic [nsr_pkg::EPS_W-1:0]    cfg_wdata,
	input  wire nsr_pkg::cmd_t                cmd,
	output nsr_pkg::status_t                  status,
	output logic      [nsr_pkg::ROOT_W-1:0]   root,
	output logic                              invalid,
	output logic                              not_converged
);

	localparam int NW = nsr_pkg::NUM_W;
	localparam int GW = nsr_pkg::GUESS_W;
	localparam int RW = nsr_pkg::ROOT_W;
	localparam int EW = nsr_pkg::EPS_W;
	localparam int DW = NW + FRAC_BITS;
	localparam int QW = (DW > GW) ? DW : GW + 1;
	localparam logic [NW-1:0] ONE_FX = NW'(1) << FRAC_BITS;

	logic [NW-1:0] num_q;
	logic [GW-1:0] last_q;
	logic [GW-1:0] next_q;
	logic [GW-1:0] rem_q;
	logic [DW-1:0] dvd_q;
	logic [QW-1:0] quo_q;
	logic [EW-1:0] eps_q;
	logic [RW-1:0] root_q;
	logic          invalid_q;
	logic          nc_q;

	logic [GW:0]   rem_sh;
	logic          q_bit;
	logic [GW-1:0] q_sat;
	logic [GW-1:0] next_d;
	logic [GW-1:0] diff;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DW-1]};
		q_bit  = (rem_sh >= {1'b0, last_q});
		if ((last_q == '0) || (|quo_q[QW-1:GW])) begin
			q_sat = '1;
		end else begin
			q_sat = quo_q[GW-1:0];
		end
		next_d = (last_q >> 1) + (q_sat >> 1) + {{(GW-1){1'b0}}, last_q[0] & q_sat[0]};
		if (last_q >= next_q) begin
			diff = last_q - next_q;
		end else begin
			diff = next_q - last_q;
		end
	end

	assign status.neg       = num_q[NW-1];
	assign status.special   = (num_q == '0) || (num_q == ONE_FX);
	assign status.converged = (diff <= {{(GW-EW){1'b0}}, eps_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= nsr_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= num;
			last_q <= {{(GW-NW){1'b0}}, num};
		end
		if (cmd.advance) begin
			last_q <= next_q;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= {num_q, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (q_bit) begin
				rem_q <= GW'(rem_sh - {1'b0, last_q});
			end else begin
				rem_q <= rem_sh[GW-1:0];
			end
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], q_bit};
		end
		if (cmd.update) begin
			next_q <= next_d;
		end
		if (cmd.write_result) begin
			priority if (num_q[NW-1]) begin
				root_q    <= '0;
				invalid_q <= 1'b1;
				nc_q      <= 1'b0;
			end else if (status.special) begin
				root_q    <= num_q[RW-1:0];
				invalid_q <= 1'b0;
				nc_q      <= 1'b0;
			end else begin
				root_q    <= (|next_q[GW-1:RW]) ? '1 : next_q[RW-1:0];
				invalid_q <= 1'b0;
				nc_q      <= cmd.not_conv;
			end
		end
	end

	assign root          = root_q;
	assign invalid       = invalid_q;
	assign not_converged = nc_q;

endmodule
`default_nettype wire

// ----- hdl/nsr_ctrl.sv -----
// Controller of the Newton square root block: state machine, divider step
// and iteration counters, handshakes. Depends on nsr_pkg.
`default_nettype none
module nsr_ctrl #(
	parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF,
	parameter int DIV_STEPS      = nsr_pkg::NUM_W + nsr_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire nsr_pkg::status_t status,
	output nsr_pkg::cmd_t         cmd
);

	localparam int CW = $clog2(DIV_STEPS);
	localparam int IW = $clog2(MAX_ITERATIONS + 1);

	typedef enum logic [5:0] {
		IDLE     = 6'b000001,
		CLASSIFY = 6'b000010,
		DIV_INIT = 6'b000100,
		DIVIDE   = 6'b001000,
		UPDATE   = 6'b010000,
		CHECK    = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		FIN_NONE = 2'b00,
		FIN_OK   = 2'b01,
		FIN_NC   = 2'b10
	} fin_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] it_q;
	logic          pend_q;
	logic          pend_nc_q;
	logic          out_valid_q;
	logic          slot_free;
	fin_t          fin;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == IDLE) && !pend_q;
	assign out_valid = out_valid_q;

	always_comb begin
		fin = FIN_NONE;
		if (state_q == CLASSIFY && (status.neg || status.special)) begin
			fin = FIN_OK;
		end else if (state_q == CHECK) begin
			if (status.converged) begin
				fin = FIN_OK;
			end else if (it_q >= IW'(MAX_ITERATIONS)) begin
				fin = FIN_NC;
			end
		end
	end

	always_comb begin
		cmd              = '0;
		cmd.load         = in_valid && in_ready;
		cmd.div_init     = (state_q == DIV_INIT);
		cmd.div_step     = (state_q == DIVIDE);
		cmd.update       = (state_q == UPDATE);
		cmd.advance      = (state_q == CHECK) && (fin == FIN_NONE);
		cmd.write_result = pend_q && slot_free;
		cmd.not_conv     = pend_nc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			it_q        <= '0;
			pend_q      <= 1'b0;
			pend_nc_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write_result) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fin != FIN_NONE) begin
				pend_q    <= 1'b1;
				pend_nc_q <= (fin == FIN_NC);
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= CLASSIFY;
					end
				end
				CLASSIFY: begin
					it_q <= '0;
					if (fin != FIN_NONE) begin
						state_q <= IDLE;
					end else begin
						state_q <= DIV_INIT;
					end
				end
				DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= DIVIDE;
				end
				DIVIDE: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DIV_STEPS - 1)) begin
						state_q <= UPDATE;
					end
				end
				UPDATE: begin
					it_q    <= it_q + IW'(1);
					state_q <= CHECK;
				end
				CHECK: begin
					if (fin != FIN_NONE) begin
						state_q <= IDLE;
					end else begin
						state_q <= DIV_INIT;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
